/* src/lskv_pkg.sv */
// lskv_pkg: shared sizes, codes, request record and helpers of the key-value store
// no dependencies; imported by lskv_front, lskv_engine and the top level
package lskv_pkg;

    localparam int BLOCK_WORDS     = 1024;
    localparam int MAX_KEY         = 255;
    localparam int MAX_VALUE_WORDS = 64;

    // address and counter widths
    localparam int AW    = $clog2(BLOCK_WORDS);
    localparam int TW    = AW + 1;
    localparam int CW    = $clog2(MAX_VALUE_WORDS + 1);
    localparam int PB_AW = (MAX_VALUE_WORDS > 1) ? $clog2(MAX_VALUE_WORDS) : 1;

    localparam logic [7:0]  END_LEN = 8'hff;
    localparam logic [31:0] ERASED  = 32'hffffffff;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_NO_MEM    = 2'd2
    } status_t;

    // one classified request on its way from front to back
    typedef struct packed {
        op_t         op;
        logic [7:0]  key;
        logic [7:0]  vlen;
        logic [31:0] data;
        logic        last;
        logic        bad;
        logic        key_ok;
    } req_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR,
        ST_RESP,
        ST_W_START,
        ST_WALK,
        ST_W_DONE,
        ST_G_HDR,
        ST_G_OUT,
        ST_A_CHECK,
        ST_A_SETUP,
        ST_A_WRITE,
        ST_C_COPY,
        ST_C_KEY,
        ST_C_REC,
        ST_C_NEXT
    } state_t;

    // words taken by a record of a given value length
    function automatic logic [6:0] rec_words(input logic [7:0] len);
        logic [8:0] sum;
        sum = {1'b0, len} + 9'd5;
        return sum[8:2];
    endfunction

    // zero the bytes whose value index base + b is at or past len
    function automatic logic [31:0] mask_bytes(input logic [31:0] w,
                                               input logic [8:0]  base,
                                               input logic [7:0]  len);
        logic [31:0] r;
        logic [8:0]  idx;
        r = w;
        for (int b = 0; b < 4; b++) begin
            idx = base + 9'(b);
            if (idx >= {1'b0, len}) begin
                r[8*b +: 8] = 8'h00;
            end
        end
        return r;
    endfunction

endpackage

/* src/lskv_front.sv */
// lskv_front: accepts requests, classifies them and holds them in a short queue
// depends on lskv_pkg
module lskv_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // key, value_len, data_word
    input  logic [1:0]        s_tuser,   // req_type
    input  logic              s_tlast,   // last
    input  logic              init_busy,
    output logic              q_valid,
    input  logic              q_pop,
    output lskv_pkg::req_t    q_head
);
    import lskv_pkg::*;

    localparam int QD = 4;

    req_t       q_mem [QD];
    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [2:0] cnt_reg, cnt_next;
    req_t       in_req;
    logic       push;

    // classify the incoming request
    always_comb begin
        in_req.op     = op_t'(s_tuser);
        in_req.key    = s_tdata[7:0];
        in_req.vlen   = s_tdata[15:8];
        in_req.data   = s_tdata[47:16];
        in_req.last   = s_tlast;
        in_req.bad    = (s_tdata[15:8] == 8'd0) || (s_tdata[15:8] == END_LEN) ||
                        ({1'b0, s_tdata[15:8]} > 9'(4 * MAX_VALUE_WORDS)) ||
                        (s_tdata[7:0] > 8'(MAX_KEY));
        in_req.key_ok = (s_tdata[7:0] <= 8'(MAX_KEY));
    end

    assign s_tready = (cnt_reg != 3'(QD)) && !init_busy;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 3'd0);
    assign q_head   = q_mem[rptr_reg];

    // queue pointers
    always_comb begin
        wptr_next = push ? wptr_reg + 2'd1 : wptr_reg;
        rptr_next = q_pop ? rptr_reg + 2'd1 : rptr_reg;
        cnt_next  = cnt_reg + 3'(push) - 3'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wptr_reg] <= in_req;
        end
    end

endmodule

/* src/lskv_engine.sv */
// lskv_engine: log store, backup store, put buffer and the sequencer that runs requests
// depends on lskv_pkg
module lskv_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_pop,
    input  lskv_pkg::req_t    q_head,
    output logic              init_busy,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // status, result_len, result_word
    output logic              m_tlast    // result_last
);
    import lskv_pkg::*;

    // memories
    logic [31:0] prim_mem [BLOCK_WORDS];
    logic [31:0] bk_mem   [BLOCK_WORDS];
    logic [31:0] pb_mem   [MAX_VALUE_WORDS];

    logic [AW-1:0]    rd_addr;
    logic [31:0]      pr_rdata, bk_rdata, pb_rdata;
    logic             pr_we, bk_we, pb_we;
    logic [AW-1:0]    pr_waddr, bk_waddr;
    logic [31:0]      pr_wdata;
    logic [PB_AW-1:0] pb_raddr;

    state_t        state_reg, state_next;
    op_t           op_reg, op_next;
    logic [7:0]    key_reg, key_next;
    logic [7:0]    vlen_reg, vlen_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [TW-1:0] tail_reg, tail_next;
    logic [TW-1:0] pos_reg, pos_next;
    logic [AW-1:0] at_reg, at_next;
    logic [7:0]    atlen_reg, atlen_next;
    logic          have_reg, have_next;
    logic [7:0]    k_reg, k_next;
    logic [6:0]    j_reg, j_next;
    logic [TW-1:0] idx_reg, idx_next;
    logic [31:0]   prev_reg, prev_next;
    status_t       stat_reg, stat_next;
    logic          comp_reg, comp_next;
    logic          compd_reg, compd_next;

    logic          m_valid_reg, m_valid_next;
    logic [47:0]   m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;

    // shared decisions
    logic [31:0]   walk_rdata, cur_pb, app_word, get_word;
    logic [7:0]    h_len, walk_key;
    logic [TW-1:0] walk_nxt;
    logic          walk_stop, live, rec_fits, app_over, out_free;
    logic          app_last, rec_last, get_last;
    logic [6:0]    app_w, rec_w;
    logic [8:0]    nsum;
    logic [6:0]    n_words;

    assign walk_rdata = comp_reg ? bk_rdata : pr_rdata;
    assign h_len      = walk_rdata[7:0];
    assign walk_key   = comp_reg ? k_reg : key_reg;
    assign walk_nxt   = pos_reg + TW'(rec_words(h_len));
    assign walk_stop  = (pos_reg >= TW'(BLOCK_WORDS)) || (h_len == END_LEN) ||
                        (walk_nxt > TW'(BLOCK_WORDS));
    assign live       = have_reg && (atlen_reg != 8'd0);
    assign rec_w      = rec_words(atlen_reg);
    assign app_w      = rec_words(vlen_reg);
    assign rec_fits   = ({1'b0, tail_reg} + (TW+1)'(rec_w)) <= (TW+1)'(BLOCK_WORDS);
    assign app_over   = ({1'b0, tail_reg} + (TW+1)'(app_w)) > (TW+1)'(BLOCK_WORDS);
    assign app_last   = (j_reg == app_w - 7'd1);
    assign rec_last   = (j_reg == rec_w - 7'd1);
    assign nsum       = {1'b0, atlen_reg} + 9'd3;
    assign n_words    = nsum[8:2];
    assign get_last   = (j_reg == n_words - 7'd1);
    assign out_free   = !m_valid_reg || m_tready;
    assign init_busy  = (state_reg == ST_INIT);

    // put buffer word, zero beyond the words received
    assign cur_pb = (7'(cnt_reg) > j_reg) ? pb_rdata : 32'd0;

    // record word being appended
    always_comb begin
        if (j_reg == 7'd0) begin
            app_word = {(vlen_reg > 8'd1) ? cur_pb[15:8] : 8'h00,
                        (vlen_reg > 8'd0) ? cur_pb[7:0]  : 8'h00,
                        key_reg, vlen_reg};
        end else begin
            app_word = mask_bytes({cur_pb[15:0], prev_reg[31:16]},
                                  {j_reg, 2'b00} - 9'd2, vlen_reg);
        end
    end

    // result word of a get
    assign get_word = mask_bytes({pr_rdata[15:0], prev_reg[31:16]},
                                 {j_reg, 2'b00}, atlen_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (idx_reg == TW'(BLOCK_WORDS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_head.op)
                        OP_PUT: begin
                            if (q_head.last) state_next = q_head.bad ? ST_RESP : ST_A_CHECK;
                        end
                        OP_GET, OP_REMOVE: begin
                            state_next = q_head.key_ok ? ST_W_START : ST_RESP;
                        end
                        default: state_next = ST_CLR;
                    endcase
                end
            end
            ST_CLR: begin
                if (idx_reg == TW'(BLOCK_WORDS - 1)) state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) state_next = ST_IDLE;
            end
            ST_W_START: state_next = ST_WALK;
            ST_WALK: begin
                if (walk_stop) state_next = ST_W_DONE;
            end
            ST_W_DONE: begin
                if (comp_reg) begin
                    state_next = (live && rec_fits) ? ST_C_REC : ST_C_NEXT;
                end else if (!live) begin
                    state_next = ST_RESP;
                end else if (op_reg == OP_GET) begin
                    state_next = ST_G_HDR;
                end else begin
                    state_next = ST_A_CHECK;
                end
            end
            ST_G_HDR: state_next = ST_G_OUT;
            ST_G_OUT: begin
                if (out_free && get_last) state_next = ST_IDLE;
            end
            ST_A_CHECK: begin
                if (app_over) state_next = compd_reg ? ST_RESP : ST_C_COPY;
                else state_next = ST_A_SETUP;
            end
            ST_A_SETUP: state_next = ST_A_WRITE;
            ST_A_WRITE: begin
                if (app_last) state_next = ST_RESP;
            end
            ST_C_COPY: begin
                if (idx_reg == TW'(BLOCK_WORDS)) state_next = ST_C_KEY;
            end
            ST_C_KEY: state_next = (k_reg == key_reg) ? ST_C_NEXT : ST_W_START;
            ST_C_REC: begin
                if (rec_last) state_next = ST_C_NEXT;
            end
            ST_C_NEXT: state_next = (k_reg == 8'(MAX_KEY)) ? ST_A_CHECK : ST_C_KEY;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        op_next      = op_reg;
        key_next     = key_reg;
        vlen_next    = vlen_reg;
        cnt_next     = cnt_reg;
        tail_next    = tail_reg;
        pos_next     = pos_reg;
        at_next      = at_reg;
        atlen_next   = atlen_reg;
        have_next    = have_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        idx_next     = idx_reg;
        prev_next    = prev_reg;
        stat_next    = stat_reg;
        comp_next    = comp_reg;
        compd_next   = compd_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        q_pop        = 1'b0;
        rd_addr      = '0;
        pr_we        = 1'b0;
        pr_waddr     = '0;
        pr_wdata     = ERASED;
        bk_we        = 1'b0;
        bk_waddr     = '0;
        pb_we        = 1'b0;
        pb_raddr     = '0;
        unique case (state_reg)
            // erase sweep after reset and for clear-all
            ST_INIT, ST_CLR: begin
                pr_we     = 1'b1;
                pr_waddr  = idx_reg[AW-1:0];
                idx_next  = idx_reg + TW'(1);
                tail_next = '0;
            end
            // take the next request from the queue
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    op_next    = q_head.op;
                    key_next   = q_head.key;
                    vlen_next  = q_head.vlen;
                    comp_next  = 1'b0;
                    compd_next = 1'b0;
                    idx_next   = '0;
                    stat_next  = STAT_OK;
                    unique case (q_head.op)
                        OP_PUT: begin
                            if (cnt_reg < CW'(MAX_VALUE_WORDS)) begin
                                pb_we    = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                            if (q_head.bad) stat_next = STAT_NO_MEM;
                        end
                        OP_GET, OP_REMOVE: begin
                            cnt_next = '0;
                            if (!q_head.key_ok) stat_next = STAT_NOT_FOUND;
                        end
                        default: cnt_next = '0;
                    endcase
                end
            end
            // single status result
            ST_RESP: begin
                cnt_next = '0;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, 32'd0, 8'd0, stat_reg};
                    m_last_next  = 1'b1;
                end
            end
            // log walk, one header a cycle
            ST_W_START: begin
                rd_addr   = '0;
                pos_next  = '0;
                have_next = 1'b0;
            end
            ST_WALK: begin
                rd_addr = walk_nxt[AW-1:0];
                if (!walk_stop) begin
                    pos_next = walk_nxt;
                    if (walk_rdata[15:8] == walk_key) begin
                        have_next  = 1'b1;
                        at_next    = pos_reg[AW-1:0];
                        atlen_next = h_len;
                    end
                end
            end
            ST_W_DONE: begin
                rd_addr = at_reg;
                j_next  = '0;
                if (!comp_reg) begin
                    if (!live) stat_next = STAT_NOT_FOUND;
                    vlen_next = 8'd0;
                end
            end
            // stream a found record
            ST_G_HDR: begin
                prev_next = pr_rdata;
                rd_addr   = at_reg + AW'(1);
            end
            ST_G_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, get_word, atlen_reg, STAT_OK};
                    m_last_next  = get_last;
                    prev_next    = pr_rdata;
                    j_next       = j_reg + 7'd1;
                    rd_addr      = at_reg + AW'(j_reg) + AW'(2);
                end else begin
                    rd_addr = at_reg + AW'(j_reg) + AW'(1);
                end
            end
            // append with compaction when the log is full
            ST_A_CHECK: begin
                idx_next = '0;
                if (app_over && compd_reg) begin
                    stat_next = (op_reg == OP_PUT) ? STAT_NO_MEM : STAT_OK;
                end
                if (app_over && !compd_reg) comp_next = 1'b1;
            end
            ST_A_SETUP: begin
                pb_raddr = '0;
                j_next   = '0;
            end
            ST_A_WRITE: begin
                pr_we     = 1'b1;
                pr_waddr  = AW'(tail_reg) + AW'(j_reg);
                pr_wdata  = app_word;
                prev_next = cur_pb;
                j_next    = j_reg + 7'd1;
                pb_raddr  = PB_AW'(j_reg + 7'd1);
                if (app_last) begin
                    tail_next = tail_reg + TW'(app_w);
                    stat_next = STAT_OK;
                end
            end
            // copy the log to backup while erasing it
            ST_C_COPY: begin
                rd_addr  = idx_reg[AW-1:0];
                idx_next = idx_reg + TW'(1);
                if (idx_reg != '0) begin
                    bk_we    = 1'b1;
                    bk_waddr = AW'(idx_reg - TW'(1));
                    pr_we    = 1'b1;
                    pr_waddr = AW'(idx_reg - TW'(1));
                end
                if (idx_reg == TW'(BLOCK_WORDS)) begin
                    k_next    = '0;
                    tail_next = '0;
                end
            end
            ST_C_KEY: begin
                rd_addr = '0;
            end
            ST_C_REC: begin
                pr_we    = 1'b1;
                pr_waddr = AW'(tail_reg) + AW'(j_reg);
                pr_wdata = bk_rdata;
                rd_addr  = at_reg + AW'(j_reg) + AW'(1);
                j_next   = j_reg + 7'd1;
                if (rec_last) tail_next = tail_reg + TW'(rec_w);
            end
            ST_C_NEXT: begin
                if (k_reg == 8'(MAX_KEY)) begin
                    comp_next  = 1'b0;
                    compd_next = 1'b1;
                end else begin
                    k_next = k_reg + 8'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            tail_reg    <= '0;
            comp_reg    <= 1'b0;
            compd_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            tail_reg    <= tail_next;
            comp_reg    <= comp_next;
            compd_reg   <= compd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        vlen_reg   <= vlen_next;
        pos_reg    <= pos_next;
        at_reg     <= at_next;
        atlen_reg  <= atlen_next;
        have_reg   <= have_next;
        k_reg      <= k_next;
        j_reg      <= j_next;
        prev_reg   <= prev_next;
        stat_reg   <= stat_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    // log store
    always_ff @(posedge aclk) begin
        if (pr_we) prim_mem[pr_waddr] <= pr_wdata;
        pr_rdata <= prim_mem[rd_addr];
    end

    // backup store
    always_ff @(posedge aclk) begin
        if (bk_we) bk_mem[bk_waddr] <= pr_rdata;
        bk_rdata <= bk_mem[rd_addr];
    end

    // put buffer
    always_ff @(posedge aclk) begin
        if (pb_we) pb_mem[cnt_reg[PB_AW-1:0]] <= q_head.data;
        pb_rdata <= pb_mem[pb_raddr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* src/log_structured_kv_store_core.sv */
// log_structured_kv_store_core: top level of the log-structured key-value store
// depends on lskv_pkg, lskv_front and lskv_engine
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tdata key,value_len,data_word; tuser req_type; tlast last
// m_        out  m_tvalid/m_tready  tdata status,result_len,result_word; tlast result_last
//
// a put word without last only goes into the put buffer; get and remove walk the log
// at one header per cycle through the log store read port. compaction copies the
// store to the backup while erasing it, then walks the backup once for each key other
// than the request's key. clear-all erases the store; after reset the same erase pass
// runs with s_tready low. a four-entry request queue lets input keep flowing while the
// back end works or waits on m_tready, until the queue fills.
module log_structured_kv_store_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // key [7:0], value_len [15:8], data_word [47:16]
    input  logic [1:0]  s_tuser,   // req_type [1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status [1:0], result_len [9:2], result_word [41:10]
    output logic        m_tlast
);
    import lskv_pkg::*;

    logic q_valid;
    logic q_pop;
    req_t q_head;
    logic init_busy;

    lskv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .init_busy (init_busy),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head)
    );

    lskv_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
